[hw/rtl/ehct_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ehct_pkg
// Shared constants, codes and interface types of the edge hit counter table.
// ----------------------------------------------------------------------------
package ehct_pkg;

    localparam int MAX_SLOTS   = 64;
    localparam int COUNT_WIDTH = 64;
    localparam int SLOT_W      = 7;   // one-based slot number, 0..MAX_SLOTS
    localparam int IDX_W       = 6;   // zero-based slot index
    localparam int ID_W        = 64;
    localparam int DATA_W      = 64;
    localparam int ADDR_W      = 5;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;

    localparam logic [1:0] REG_PRODUCER_ENABLE = 2'd0;
    localparam logic [1:0] REG_SLOTS_IN_USE    = 2'd1;
    localparam logic [1:0] REG_LAYOUT_TAG      = 2'd2;

    localparam logic [REQ_W-1:0] REQ_HIT     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BEGIN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BUSY     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

    typedef struct packed {
        logic              producer_enable;
        logic [SLOT_W-1:0] slots_in_use;
        logic [ID_W-1:0]   layout_tag;
    } t_cfg;

    typedef struct packed {
        logic              req_load;
        logic              mem_rd;
        logic              rd_from_idx;
        logic              hit_write;
        logic              begin_commit;
        logic              end_stop;
        logic              idx_clear;
        logic              idx_inc;
        logic              out_load_single;
        logic              out_load_count;
        logic [STAT_W-1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic              hit_ok;
        logic [STAT_W-1:0] begin_status;
        logic [STAT_W-1:0] end_status;
        logic              idx_last;
        logic              out_free;
    } t_sts;

endpackage
`default_nettype wire

[hw/rtl/edge_hit_counter_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// edge_hit_counter_table
// Per-edge 64-bit hit counters with begin/end run control and readout.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A counted hit passes through accept,
// counter read and counter write in the single-port counter memory with
// registered read; an ignored hit skips the read and the write. Begin and end
// replies wait for the result register to drain. A successful end streams
// one result per registered slot, each by a memory read and then a load into
// the result register, which waits while that register is full. Begin clears
// the table through per-slot valid flags, so there is no clearing pass after
// reset or begin. Results sit in an output register; configuration registers
// are at byte addresses 0, 8 and 16.
// ----------------------------------------------------------------------------
module edge_hit_counter_table
    import ehct_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic      [DATA_W-1:0]      prdata,
    output logic                        pready,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [REQ_W-1:0]       i_req_type,
    input  wire logic [SLOT_W-1:0]      i_slot,
    input  wire logic [ID_W-1:0]        i_run_id,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [STAT_W-1:0]      o_status,
    output logic      [IDX_W-1:0]       o_slot_index,
    output logic      [COUNT_WIDTH-1:0] o_hit_count,
    output logic      [ID_W-1:0]        o_run_id_out,
    output logic      [ID_W-1:0]        o_layout_tag_out,
    output logic                        o_last
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    ehct_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ehct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ehct_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_req_type),
        .i_slot           (i_slot),
        .i_run_id         (i_run_id),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_slot_index     (o_slot_index),
        .o_hit_count      (o_hit_count),
        .o_run_id_out     (o_run_id_out),
        .o_layout_tag_out (o_layout_tag_out),
        .o_last           (o_last)
    );

endmodule
`default_nettype wire

[hw/rtl/ehct_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ehct_regs
// APB-style configuration registers: producer enable, slot count, layout tag.
// ----------------------------------------------------------------------------
module ehct_regs
    import ehct_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:3];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_PRODUCER_ENABLE: r_cfg.producer_enable <= pwdata[0];
                REG_SLOTS_IN_USE:    r_cfg.slots_in_use    <= pwdata[SLOT_W-1:0];
                REG_LAYOUT_TAG:      r_cfg.layout_tag      <= pwdata[ID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_PRODUCER_ENABLE: prdata = {{(DATA_W-1){1'b0}}, r_cfg.producer_enable};
            REG_SLOTS_IN_USE:    prdata = {{(DATA_W-SLOT_W){1'b0}}, r_cfg.slots_in_use};
            REG_LAYOUT_TAG:      prdata = r_cfg.layout_tag;
            default:             prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/ehct_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ehct_datapath
// Counter memory, run state, request latch and result register.
// ----------------------------------------------------------------------------
module ehct_datapath
    import ehct_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_cfg                   i_cfg,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  wire logic [REQ_W-1:0]  i_req_type,
    input  wire logic [SLOT_W-1:0] i_slot,
    input  wire logic [ID_W-1:0]   i_run_id,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [STAT_W-1:0] o_status,
    output logic      [IDX_W-1:0]  o_slot_index,
    output logic [COUNT_WIDTH-1:0] o_hit_count,
    output logic      [ID_W-1:0]   o_run_id_out,
    output logic      [ID_W-1:0]   o_layout_tag_out,
    output logic                   o_last
);

    logic [COUNT_WIDTH-1:0] mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]   r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_valid;

    logic [REQ_W-1:0]  r_req;
    logic [SLOT_W-1:0] r_slot;
    logic [ID_W-1:0]   r_rid;
    logic [IDX_W-1:0]  r_idx;

    logic              r_run_active;
    logic              r_overflow;
    logic [ID_W-1:0]   r_prev_rid;

    logic                   r_out_valid;
    logic [STAT_W-1:0]      r_out_status;
    logic [IDX_W-1:0]       r_out_idx;
    logic [COUNT_WIDTH-1:0] r_out_count;
    logic [ID_W-1:0]        r_out_rid;
    logic [ID_W-1:0]        r_out_lid;
    logic                   r_out_last;

    logic                   cfg_ready;
    logic [SLOT_W-1:0]      nslots;
    logic [SLOT_W-1:0]      slot_m1;
    logic [IDX_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] old_count;
    logic                   out_free;

    assign cfg_ready = (i_cfg.slots_in_use != '0) && (i_cfg.layout_tag != '0);
    assign nslots    = (i_cfg.slots_in_use > SLOT_W'(MAX_SLOTS)) ? SLOT_W'(MAX_SLOTS)
                                                                 : i_cfg.slots_in_use;
    assign slot_m1   = r_slot - SLOT_W'(1);
    assign rd_addr   = i_cmd.rd_from_idx ? r_idx : slot_m1[IDX_W-1:0];
    assign old_count = r_rd_valid ? r_rd_data : '0;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.req      = r_req;
        o_sts.hit_ok   = i_cfg.producer_enable && cfg_ready && r_run_active &&
                         (r_slot != '0) && (r_slot <= nslots);
        o_sts.idx_last = ({1'b0, r_idx} == (nslots - SLOT_W'(1)));
        o_sts.out_free = out_free;
        if (!cfg_ready || r_rid == '0) begin
            o_sts.begin_status = STAT_INVALID;
        end else if (r_run_active) begin
            o_sts.begin_status = STAT_BUSY;
        end else if (r_rid <= r_prev_rid) begin
            o_sts.begin_status = STAT_INVALID;
        end else begin
            o_sts.begin_status = STAT_OK;
        end
        if (!cfg_ready || !r_run_active) begin
            o_sts.end_status = STAT_INVALID;
        end else if (r_overflow) begin
            o_sts.end_status = STAT_OVERFLOW;
        end else begin
            o_sts.end_status = STAT_OK;
        end
    end

    // counter memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_write) begin
            mem[slot_m1[IDX_W-1:0]] <= old_count + COUNT_WIDTH'(1);
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_rd_valid   <= 1'b0;
            r_run_active <= 1'b0;
            r_overflow   <= 1'b0;
            r_prev_rid   <= '0;
            r_idx        <= '0;
        end else begin
            if (i_cmd.mem_rd) begin
                r_rd_valid <= r_valid[rd_addr];
            end
            if (i_cmd.begin_commit) begin
                r_valid      <= '0;
                r_overflow   <= 1'b0;
                r_prev_rid   <= r_rid;
                r_run_active <= 1'b1;
            end else if (i_cmd.hit_write) begin
                r_valid[slot_m1[IDX_W-1:0]] <= 1'b1;
                if (&old_count) begin
                    r_overflow <= 1'b1;
                end
            end
            if (i_cmd.end_stop) begin
                r_run_active <= 1'b0;
            end
            if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req  <= i_req_type;
            r_slot <= i_slot;
            r_rid  <= i_run_id;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_single || i_cmd.out_load_count) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_single) begin
            r_out_status <= i_cmd.out_status;
            r_out_idx    <= '0;
            r_out_count  <= '0;
            r_out_rid    <= '0;
            r_out_lid    <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.out_load_count) begin
            r_out_status <= STAT_OK;
            r_out_idx    <= r_idx;
            r_out_count  <= old_count;
            r_out_rid    <= r_prev_rid;
            r_out_lid    <= i_cfg.layout_tag;
            r_out_last   <= o_sts.idx_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_slot_index     = r_out_idx;
    assign o_hit_count      = r_out_count;
    assign o_run_id_out     = r_out_rid;
    assign o_layout_tag_out = r_out_lid;
    assign o_last           = r_out_last;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load_single || i_cmd.out_load_count) |-> out_free)
        else $error("result register overwritten before it was taken");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_write |-> $past(i_cmd.mem_rd && !i_cmd.rd_from_idx))
        else $error("counter written without a preceding read");

    a_begin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.begin_commit |=> (r_run_active && !r_overflow && r_valid == '0))
        else $error("begin did not clear the table");

    a_stream_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load_count |-> (!r_run_active && !r_overflow))
        else $error("readout while a run is active or overflowed");

endmodule
`default_nettype wire

[hw/rtl/ehct_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ehct_ctrl
// Sequencer: request decode, counter read-modify-write and slot readout.
// ----------------------------------------------------------------------------
module ehct_ctrl
    import ehct_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  t_sts      i_sts,
    output t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_HIT_WR = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_RD_OUT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.req)
                    REQ_HIT: begin
                        if (i_sts.hit_ok) begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = S_HIT_WR;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    REQ_BEGIN: begin
                        if (i_sts.out_free) begin
                            o_cmd.out_load_single = 1'b1;
                            o_cmd.out_status      = i_sts.begin_status;
                            o_cmd.begin_commit    = (i_sts.begin_status == STAT_OK);
                            n_state               = S_IDLE;
                        end
                    end
                    REQ_END: begin
                        if (i_sts.end_status == STAT_OK) begin
                            o_cmd.end_stop  = 1'b1;
                            o_cmd.idx_clear = 1'b1;
                            n_state         = S_RD;
                        end else if (i_sts.out_free) begin
                            o_cmd.out_load_single = 1'b1;
                            o_cmd.out_status      = i_sts.end_status;
                            o_cmd.end_stop        = (i_sts.end_status == STAT_OVERFLOW);
                            n_state               = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_HIT_WR: begin
                o_cmd.hit_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_RD: begin
                o_cmd.mem_rd      = 1'b1;
                o_cmd.rd_from_idx = 1'b1;
                n_state           = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load_count = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire
